>>> hw/rtl/tld_pkg.sv
// ----------------------------------------------------------------------------
// tld_pkg
// Shared types, constants and helpers for the terminal line discipline core.
// ----------------------------------------------------------------------------
package tld_pkg;

    // sizes
    localparam int RING_DEPTH = 32768;
    localparam int LINE_MAX   = 4096;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int LINE_W     = $clog2(LINE_MAX + 1);
    localparam int SUM_W      = ((CNT_W > LINE_W) ? CNT_W : LINE_W) + 1;
    localparam int EOF_W      = 16;
    localparam logic [EOF_W-1:0] EOF_MAX = {EOF_W{1'b1}};

    // command queue between front and back
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);
    localparam int STEP_W  = 2;

    // characters
    localparam logic [7:0] CH_CR = 8'h0d;
    localparam logic [7:0] CH_LF = 8'h0a;
    localparam logic [7:0] CH_BS = 8'h08;
    localparam logic [7:0] CH_SP = 8'h20;

    // mode flag bit positions
    localparam int MF_ICRNL  = 0;
    localparam int MF_OPOST  = 1;
    localparam int MF_ONLCR  = 2;
    localparam int MF_ISIG   = 3;
    localparam int MF_ICANON = 4;
    localparam int MF_ECHO   = 5;
    localparam int MF_ECHOE  = 6;
    localparam int MODE_W    = 7;

    typedef enum logic [1:0] {
        FUNC_KEY   = 2'd0,
        FUNC_OUT   = 2'd1,
        FUNC_POP   = 2'd2,
        FUNC_FLUSH = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        CFG_MODE  = 3'd0,
        CFG_INTR  = 3'd1,
        CFG_QUIT  = 3'd2,
        CFG_ERASE = 3'd3,
        CFG_KILL  = 3'd4,
        CFG_EOF   = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        KIND_TERM   = 3'd0,
        KIND_READ   = 3'd1,
        KIND_INTR   = 3'd2,
        KIND_QUIT   = 3'd3,
        KIND_EOF    = 3'd4,
        KIND_NODATA = 3'd5,
        KIND_FULL   = 3'd6
    } kind_t;

    // result sequence a command expands into
    typedef enum logic [2:0] {
        SEQ_NONE  = 3'd0,   // no result
        SEQ_ONE   = 3'd1,   // one result of given kind and byte
        SEQ_CRB   = 3'd2,   // cr then byte
        SEQ_ERASE = 3'd3,   // backspace, space, backspace
        SEQ_READ  = 3'd4    // byte read from the ring
    } seq_t;

    typedef struct packed {
        seq_t              seq;
        kind_t             kind;
        logic [7:0]        data;
        logic              canon;
        logic              we;
        logic [PTR_W-1:0]  addr;
    } cmd_t;

    // ring pointer advance, inc never exceeds the ring depth
    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                                 input logic [SUM_W-1:0] inc);
        logic [SUM_W-1:0] s;
        s = SUM_W'(p) + inc;
        if (s >= SUM_W'(RING_DEPTH))
        begin
            s = s - SUM_W'(RING_DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

endpackage

>>> hw/rtl/terminal_line_discipline_core.sv
// ----------------------------------------------------------------------------
// terminal_line_discipline_core
// Terminal line discipline, canonical or non-canonical, with a single input ring memory.
// ----------------------------------------------------------------------------
// The front stage takes one request per cycle while the command queue is not
// full (keyboard byte, program output byte, reader pop or flush), updates the
// ring pointers and counts at once and queues one command; the back stage
// performs the ring write or read and delivers that command's up to three
// results into an output register, one per cycle unless the output stalls.
// Unstalled, sustained rate is one request per cycle for requests with at
// most one result; longer requests hold the back stage until their last
// result is out, and the four-entry command queue absorbs bursts. A request's
// first result passes the command queue, command issue with ring read, then
// the output register. The ring contents need no clearing after reset, so
// requests are taken from the first cycle. Configuration writes are taken in
// any cycle in which no request is taken and belong in idle periods.
module terminal_line_discipline_core
    import tld_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] func,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] out_kind,
    output logic [7:0] out_byte,
    output logic       line_end,
    output logic       last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    cmd_t q_din;
    cmd_t q_head;

    // register writes yield to a request taken in the same cycle
    assign cfg_ready = !q_push;

    // classify front
    tld_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .data_byte (data_byte),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .push      (q_push),
        .cmd       (q_din)
    );

    // command queue
    tld_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .full  (q_full),
        .pop   (q_pop),
        .valid (q_valid),
        .dout  (q_head)
    );

    // execute back
    tld_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_kind  (out_kind),
        .out_byte  (out_byte),
        .line_end  (line_end),
        .last      (last)
    );

    // line end only on read bytes
    a_line_end_read: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && line_end) |-> (out_kind == KIND_READ))
        else $error("line_end set on a non-read result");

    // status results carry no byte and always end their request
    a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_kind != KIND_TERM && out_kind != KIND_READ)
            |-> (out_byte == 8'd0 && last))
        else $error("status result with byte or without last");

    // read byte is always the sole result of its request
    a_read_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_kind == KIND_READ) |-> last)
        else $error("read result not marked last");

endmodule

>>> hw/rtl/tld_ram.sv
// ----------------------------------------------------------------------------
// tld_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/tld_fifo.sv
// ----------------------------------------------------------------------------
// tld_fifo
// Short command queue between the classify front and the execute back.
// ----------------------------------------------------------------------------
module tld_fifo
    import tld_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t din,
    output logic full,
    input  logic pop,
    output logic valid,
    output cmd_t dout
);

    cmd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    assign full  = (cnt_reg == QCNT_W'(QDEPTH));
    assign valid = (cnt_reg != '0);
    assign dout  = mem_reg[rd_ptr_reg];

endmodule

>>> hw/rtl/tld_front.sv
// ----------------------------------------------------------------------------
// tld_front
// Accepts requests, holds configuration and ring pointers, classifies each
// request and queues one command describing memory access and results.
// ----------------------------------------------------------------------------
module tld_front
    import tld_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] func,
    input  logic [7:0] data_byte,
    input  logic       cfg_valid,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       q_full,
    output logic       push,
    output cmd_t       cmd
);

    logic [MODE_W-1:0] mode_reg;
    logic [7:0]        intr_reg;
    logic [7:0]        quit_reg;
    logic [7:0]        erase_reg;
    logic [7:0]        kill_reg;
    logic [7:0]        eofc_reg;

    logic [PTR_W-1:0]  rp_reg, rp_next;
    logic [PTR_W-1:0]  cp_reg, cp_next;
    logic [CNT_W-1:0]  cc_reg, cc_next;
    logic [LINE_W-1:0] el_reg, el_next;
    logic [EOF_W-1:0]  eof_reg, eof_next;

    logic              cfg_we;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    // a register write waits while a request is being taken
    assign cfg_we   = cfg_valid && !push;

    // classify request and compute next pointer state
    always_comb
    begin
        logic [7:0]        ch;
        logic              canon;
        logic              is_eof;
        logic [LINE_W-1:0] el1;
        logic [SUM_W-1:0]  fill;

        rp_next  = rp_reg;
        cp_next  = cp_reg;
        cc_next  = cc_reg;
        el_next  = el_reg;
        eof_next = eof_reg;

        ch = data_byte;
        if (ch == CH_CR && mode_reg[MF_ICRNL])
        begin
            ch = CH_LF;
        end
        canon  = mode_reg[MF_ICANON];
        is_eof = canon && (ch != 8'd0) && (ch == eofc_reg);
        el1    = el_reg;
        fill   = SUM_W'(cc_reg) + SUM_W'(el_reg);

        cmd.seq   = SEQ_NONE;
        cmd.kind  = KIND_TERM;
        cmd.data  = ch;
        cmd.canon = canon;
        cmd.we    = 1'b0;
        cmd.addr  = ptr_add(cp_reg, SUM_W'(el_reg));

        if (push)
        begin
            unique case (func_t'(func))
                FUNC_KEY:
                begin
                    priority if (fill >= SUM_W'(RING_DEPTH))
                    begin
                        // ring full, reject
                        cmd.seq  = SEQ_ONE;
                        cmd.kind = KIND_FULL;
                        cmd.data = 8'd0;
                    end
                    else if (mode_reg[MF_ISIG] && (ch != 8'd0) &&
                             (ch == intr_reg || ch == quit_reg))
                    begin
                        // signal character, interrupt wins
                        cmd.seq  = SEQ_ONE;
                        cmd.kind = (ch == intr_reg) ? KIND_INTR : KIND_QUIT;
                        cmd.data = 8'd0;
                        rp_next  = '0;
                        cp_next  = '0;
                        cc_next  = '0;
                        el_next  = '0;
                    end
                    else if (canon && (ch != 8'd0) && (ch == erase_reg))
                    begin
                        // erase last edited byte
                        if (el_reg != '0)
                        begin
                            el_next = el_reg - 1'b1;
                            if (mode_reg[MF_ECHO] && mode_reg[MF_ECHOE])
                            begin
                                cmd.seq = SEQ_ERASE;
                            end
                        end
                    end
                    else if (canon && (ch != 8'd0) && (ch == kill_reg))
                    begin
                        // kill edited line
                        el_next = '0;
                        if (mode_reg[MF_ECHO])
                        begin
                            cmd.seq  = SEQ_CRB;
                            cmd.data = CH_LF;
                        end
                    end
                    else
                    begin
                        // store byte and commit where the line ends
                        if (canon)
                        begin
                            if (!is_eof && el_reg < LINE_W'(LINE_MAX))
                            begin
                                cmd.we = 1'b1;
                                el1    = el_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            cmd.we = 1'b1;
                            el1    = el_reg + 1'b1;
                        end
                        if (!canon || ch == CH_LF || is_eof || el1 >= LINE_W'(LINE_MAX))
                        begin
                            if (is_eof && el1 == '0 && eof_reg != EOF_MAX)
                            begin
                                eof_next = eof_reg + 1'b1;
                            end
                            cp_next = ptr_add(cp_reg, SUM_W'(el1));
                            cc_next = CNT_W'(SUM_W'(cc_reg) + SUM_W'(el1));
                            el_next = '0;
                        end
                        else
                        begin
                            el_next = el1;
                        end
                        // echo
                        if (!is_eof && mode_reg[MF_ECHO])
                        begin
                            cmd.seq = (ch == CH_LF) ? SEQ_CRB : SEQ_ONE;
                        end
                    end
                end
                FUNC_OUT:
                begin
                    cmd.data = data_byte;
                    if (data_byte == CH_LF && mode_reg[MF_OPOST] && mode_reg[MF_ONLCR])
                    begin
                        cmd.seq = SEQ_CRB;
                    end
                    else
                    begin
                        cmd.seq = SEQ_ONE;
                    end
                end
                FUNC_POP:
                begin
                    cmd.data = 8'd0;
                    priority if (cc_reg != '0)
                    begin
                        cmd.seq  = SEQ_READ;
                        cmd.kind = KIND_READ;
                        cmd.addr = rp_reg;
                        rp_next  = ptr_add(rp_reg, SUM_W'(1));
                        cc_next  = cc_reg - 1'b1;
                    end
                    else if (eof_reg != '0)
                    begin
                        cmd.seq  = SEQ_ONE;
                        cmd.kind = KIND_EOF;
                        eof_next = eof_reg - 1'b1;
                    end
                    else
                    begin
                        cmd.seq  = SEQ_ONE;
                        cmd.kind = KIND_NODATA;
                    end
                end
                FUNC_FLUSH:
                begin
                    rp_next  = '0;
                    cp_next  = '0;
                    cc_next  = '0;
                    el_next  = '0;
                    eof_next = '0;
                end
            endcase
        end
        else if (cfg_we && cfg_index == CFG_MODE && canon && !cfg_data[MF_ICANON])
        begin
            // leaving canonical mode commits the edited line
            cp_next = ptr_add(cp_reg, SUM_W'(el_reg));
            cc_next = CNT_W'(SUM_W'(cc_reg) + SUM_W'(el_reg));
            el_next = '0;
        end
    end

    // pointer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg  <= '0;
            cp_reg  <= '0;
            cc_reg  <= '0;
            el_reg  <= '0;
            eof_reg <= '0;
        end
        else
        begin
            rp_reg  <= rp_next;
            cp_reg  <= cp_next;
            cc_reg  <= cc_next;
            el_reg  <= el_next;
            eof_reg <= eof_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= {MODE_W{1'b1}};
            intr_reg  <= 8'd3;
            quit_reg  <= 8'd28;
            erase_reg <= 8'd127;
            kill_reg  <= 8'd21;
            eofc_reg  <= 8'd4;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MODE:  mode_reg  <= cfg_data[MODE_W-1:0];
                CFG_INTR:  intr_reg  <= cfg_data;
                CFG_QUIT:  quit_reg  <= cfg_data;
                CFG_ERASE: erase_reg <= cfg_data;
                CFG_KILL:  kill_reg  <= cfg_data;
                CFG_EOF:   eofc_reg  <= cfg_data;
                default:   ;
            endcase
        end
    end

endmodule

>>> hw/rtl/tld_back.sv
// ----------------------------------------------------------------------------
// tld_back
// Executes queued commands: ring memory write or read, then expands each
// command into its results through a one-deep output register.
// ----------------------------------------------------------------------------
module tld_back
    import tld_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  cmd_t       q_head,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] out_kind,
    output logic [7:0] out_byte,
    output logic       line_end,
    output logic       last
);

    cmd_t              act_reg, act_next;
    logic              act_valid_reg, act_valid_next;
    logic [STEP_W-1:0] step_reg, step_next;

    logic              out_valid_reg;
    kind_t             out_kind_reg;
    logic [7:0]        out_byte_reg;
    logic              line_end_reg;
    logic              last_reg;

    logic              emit;
    logic              fin;
    logic [7:0]        rdata;
    kind_t             res_kind;
    logic [7:0]        res_byte;
    logic              res_le;
    logic              res_last;

    // ring memory
    tld_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (q_pop && q_head.we),
        .waddr (q_head.addr),
        .wdata (q_head.data),
        .re    (q_pop && q_head.seq == SEQ_READ),
        .raddr (q_head.addr),
        .rdata (rdata)
    );

    // result for the current step of the active command
    always_comb
    begin
        res_kind = KIND_TERM;
        res_byte = act_reg.data;
        res_le   = 1'b0;
        res_last = 1'b1;
        unique case (act_reg.seq)
            SEQ_ONE:
            begin
                res_kind = act_reg.kind;
            end
            SEQ_CRB:
            begin
                res_byte = (step_reg == '0) ? CH_CR : act_reg.data;
                res_last = (step_reg == STEP_W'(1));
            end
            SEQ_ERASE:
            begin
                res_byte = (step_reg == STEP_W'(1)) ? CH_SP : CH_BS;
                res_last = (step_reg == STEP_W'(2));
            end
            SEQ_READ:
            begin
                res_kind = KIND_READ;
                res_byte = rdata;
                res_le   = act_reg.canon && (rdata == CH_LF);
            end
            default:
            begin
                res_last = 1'b1;
            end
        endcase
    end

    // step sequencing and dequeue
    assign emit  = act_valid_reg && (!out_valid_reg || out_ready);
    assign fin   = emit && res_last;
    assign q_pop = q_valid && (!act_valid_reg || fin);

    always_comb
    begin
        act_next       = act_reg;
        act_valid_next = act_valid_reg;
        step_next      = step_reg;
        if (q_pop)
        begin
            act_next       = q_head;
            act_valid_next = (q_head.seq != SEQ_NONE);
            step_next      = '0;
        end
        else if (fin)
        begin
            act_valid_next = 1'b0;
        end
        else if (emit)
        begin
            step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            act_valid_reg <= act_valid_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg <= act_next;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_kind_reg <= res_kind;
            out_byte_reg <= res_byte;
            line_end_reg <= res_le;
            last_reg     <= res_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_byte  = out_byte_reg;
    assign line_end  = line_end_reg;
    assign last      = last_reg;

endmodule
